// File: rtl/gbn_pkg.sv
`default_nettype none

package gbn_pkg;

    // Build defaults for the top-level parameters.
    localparam int GBN_MAX_BOXES  = 64;
    localparam int GBN_COORD_BITS = 16;

    // Fixed field widths.
    localparam int SCORE_W      = 16;
    localparam int CLASS_W      = 8;
    localparam int KEPT_IDX_W   = 6;
    localparam int MAXDET_W     = 7;
    localparam int RESULT_LIMIT = 64;

    // Configuration port.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [SCORE_W-1:0]  CONF_RESET    = 16'd16384;
    localparam logic [SCORE_W-1:0]  OVERLAP_RESET = 16'd29491;
    localparam logic [MAXDET_W-1:0] MAXDET_RESET  = 7'd64;

    // Register index, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_CONF    = 2'd0,
        REG_OVERLAP = 2'd1,
        REG_MAXDET  = 2'd2
    } reg_idx_t;

    // One candidate detection.
    typedef struct packed {
        logic [15:0]        center_x;
        logic [15:0]        center_y;
        logic [15:0]        box_width;
        logic [15:0]        box_height;
        logic [SCORE_W-1:0] score;
        logic [CLASS_W-1:0] box_class;
        logic               last_box;
    } box_req_t;

    // One kept detection.
    typedef struct packed {
        logic [KEPT_IDX_W-1:0] kept_index;
        logic [CLASS_W-1:0]    kept_class;
        logic                  none_kept;
        logic                  last_result;
    } result_t;

    // Commands broadcast to every cell of the sorted chain.
    typedef struct packed {
        logic insert;
        logic shift;
        logic clear;
    } chain_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/gbn_cell.sv
`default_nettype none

module gbn_cell
    import gbn_pkg::*;
#(
    parameter int ENT_W = 64
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire chain_ctrl_t       ctrl,
    input  wire logic [ENT_W-1:0]  new_ent,
    input  wire logic [ENT_W-1:0]  left_ent,
    input  wire logic              left_valid,
    input  wire logic              left_go,
    input  wire logic [ENT_W-1:0]  right_ent,
    input  wire logic              right_valid,
    output logic [ENT_W-1:0]       ent,
    output logic                   valid,
    output logic                   go
);

    logic [ENT_W-1:0] ent_reg;
    logic             valid_reg;

    // A new entry belongs at or before this cell when it outscores the
    // held one; ties stay behind so arrival order is kept.
    assign go = !valid_reg ||
                (new_ent[ENT_W-1 -: SCORE_W] > ent_reg[ENT_W-1 -: SCORE_W]);

    // Occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.shift)
        begin
            valid_reg <= right_valid;
        end
        else if (ctrl.insert && go)
        begin
            valid_reg <= left_go ? left_valid : 1'b1;
        end
    end

    // Entry contents: take the right neighbor when draining; on an insertion,
    // take the left neighbor to make room, or the new entry itself.
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            ent_reg <= right_ent;
        end
        else if (ctrl.insert && go)
        begin
            ent_reg <= left_go ? left_ent : new_ent;
        end
    end

    assign ent   = ent_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

// File: rtl/gbn_iou.sv
`default_nettype none

module gbn_iou
    import gbn_pkg::*;
#(
    parameter int COORD_BITS = GBN_COORD_BITS
)
(
    input  wire logic                              clk,
    input  wire logic signed [COORD_BITS+2:0]      k_x1,
    input  wire logic signed [COORD_BITS+2:0]      k_y1,
    input  wire logic signed [COORD_BITS+2:0]      k_x2,
    input  wire logic signed [COORD_BITS+2:0]      k_y2,
    input  wire logic        [2*COORD_BITS+1:0]    k_area,
    input  wire logic signed [COORD_BITS+2:0]      c_x1,
    input  wire logic signed [COORD_BITS+2:0]      c_y1,
    input  wire logic signed [COORD_BITS+2:0]      c_x2,
    input  wire logic signed [COORD_BITS+2:0]      c_y2,
    input  wire logic        [2*COORD_BITS+1:0]    c_area,
    input  wire logic        [SCORE_W-1:0]         threshold,
    output logic                                   hit
);

    localparam int CW = COORD_BITS + 3;
    localparam int IW = COORD_BITS + 1;
    localparam int AW = 2 * COORD_BITS + 2;

    logic signed [CW-1:0] lx, ly, hx, hy;
    logic        [CW:0]   dx, dy;
    logic        [IW-1:0] iw, ih;

    logic [IW-1:0]    iw1_reg, ih1_reg;
    logic [AW:0]      sum1_reg, sum2_reg;
    logic [AW-1:0]    inter2_reg;
    logic [AW:0]      uni3_reg;
    logic [AW+15:0]   lhs3_reg;
    logic [AW+16:0]   prod;

    // Overlap extent on each axis, clamped at zero.
    always_comb
    begin
        lx = (k_x1 > c_x1) ? k_x1 : c_x1;
        ly = (k_y1 > c_y1) ? k_y1 : c_y1;
        hx = (k_x2 < c_x2) ? k_x2 : c_x2;
        hy = (k_y2 < c_y2) ? k_y2 : c_y2;
        dx = {hx[CW-1], hx} - {lx[CW-1], lx};
        dy = {hy[CW-1], hy} - {ly[CW-1], ly};
        iw = (!dx[CW] && dx != '0) ? dx[IW-1:0] : '0;
        ih = (!dy[CW] && dy != '0) ? dy[IW-1:0] : '0;
    end

    // Stage one: extents and the area sum.
    always_ff @(posedge clk)
    begin
        iw1_reg  <= iw;
        ih1_reg  <= ih;
        sum1_reg <= {1'b0, k_area} + {1'b0, c_area};
    end

    // Stage two: intersection area.
    always_ff @(posedge clk)
    begin
        inter2_reg <= iw1_reg * ih1_reg;
        sum2_reg   <= sum1_reg;
    end

    // Stage three: union and the scaled intersection.
    always_ff @(posedge clk)
    begin
        uni3_reg <= sum2_reg - {1'b0, inter2_reg};
        lhs3_reg <= {inter2_reg, 16'd0};
    end

    // Cross-multiplied test; an empty union never suppresses.
    assign prod = threshold * uni3_reg;
    assign hit  = (uni3_reg != '0) && ({1'b0, lhs3_reg} > prod);

endmodule

`default_nettype wire

// File: rtl/greedy_box_nms.sv
`default_nettype none

// Greedy non-maximum suppression over one set of detections. Requests are
// taken one per cycle while busy is low; each passing candidate is inserted
// at once into a score-sorted chain of MAX_BOXES cells. The request marked
// last_box closes the set and raises busy. The chain then drains from its
// head: a suppressed entry is dropped, and after a kept entry the remaining
// chain is rotated once through a three-stage IoU pipeline. A finishing
// state then closes the set. Results appear on result for one cycle,
// marked by result_strobe; they cannot be held off and must be taken then.
// Configuration must be written only while busy is low; the block itself
// does not enforce this.
module greedy_box_nms
    import gbn_pkg::*;
#(
    parameter int MAX_BOXES  = GBN_MAX_BOXES,
    parameter int COORD_BITS = GBN_COORD_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  start,
    output logic                       busy,
    input  wire box_req_t              request,
    output result_t                    result,
    output logic                       result_strobe
);

    localparam int CW     = COORD_BITS + 3;
    localparam int AW     = 2 * COORD_BITS + 2;
    localparam int IDX_W  = $clog2(MAX_BOXES);
    localparam int LW     = $clog2(MAX_BOXES + 1);
    localparam int RING   = MAX_BOXES + 3;
    localparam int SW     = $clog2(RING);

    typedef struct packed {
        logic [IDX_W-1:0]     idx;
        logic [CLASS_W-1:0]   cls;
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] y1;
        logic signed [CW-1:0] x2;
        logic signed [CW-1:0] y2;
        logic [AW-1:0]        area;
        logic                 supp;
    } data_t;

    localparam int DATA_W = $bits(data_t);
    localparam int ENT_W  = SCORE_W + DATA_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_SWEEP  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t               state_reg;
    logic [SCORE_W-1:0]   conf_reg;
    logic [SCORE_W-1:0]   overlap_reg;
    logic [MAXDET_W-1:0]  maxdet_reg;
    logic [LW-1:0]        loaded_reg;
    logic [MAXDET_W-1:0]  cnt_reg;
    logic [SW-1:0]        sweep_reg;
    logic                 have_pend_reg;
    logic [KEPT_IDX_W-1:0] pend_idx_reg;
    logic [CLASS_W-1:0]   pend_cls_reg;
    data_t                k_reg;
    result_t              result_reg;
    logic                 result_strobe_reg;
    logic [ENT_W-1:0]     pipe_ent_reg [3];
    logic                 pipe_valid_reg [3];

    logic [ENT_W-1:0]     cell_ent   [MAX_BOXES];
    logic                 cell_valid [MAX_BOXES];
    logic                 cell_go    [MAX_BOXES];

    chain_ctrl_t          ctrl;
    logic                 accept;
    logic                 cfg_write;
    logic [MAXDET_W-1:0]  limit;
    logic [COORD_BITS+15:0] cx_w, cy_w, w_w, h_w;
    logic [COORD_BITS-1:0]  cx_m, cy_m, w_m, h_m;
    logic [CW-1:0]        dbl_x, dbl_y, ext_w, ext_h;
    data_t                new_d;
    logic [ENT_W-1:0]     new_ent;
    data_t                head_d;
    data_t                tail_d;
    logic [ENT_W-1:0]     tail_ent;
    logic                 tail_valid;
    logic                 iou_hit;
    logic [IDX_W+5:0]     head_idx_ext;
    logic [KEPT_IDX_W-1:0] head_idx;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    // Register read-back.
    always_comb
    begin
        unique case (paddr[3:2])
            REG_CONF:    prdata = {16'd0, conf_reg};
            REG_OVERLAP: prdata = {16'd0, overlap_reg};
            REG_MAXDET:  prdata = {25'd0, maxdet_reg};
            default:     prdata = '0;
        endcase
    end

    // Clamp the result limit to one through the result capacity.
    always_comb
    begin
        if (maxdet_reg == '0)
        begin
            limit = MAXDET_W'(1);
        end
        else if (maxdet_reg > MAXDET_W'(RESULT_LIMIT))
        begin
            limit = MAXDET_W'(RESULT_LIMIT);
        end
        else
        begin
            limit = maxdet_reg;
        end
    end

    // Corner form at twice the input scale, plus the box area.
    always_comb
    begin
        cx_w  = {COORD_BITS'(0), request.center_x};
        cy_w  = {COORD_BITS'(0), request.center_y};
        w_w   = {COORD_BITS'(0), request.box_width};
        h_w   = {COORD_BITS'(0), request.box_height};
        cx_m  = cx_w[COORD_BITS-1:0];
        cy_m  = cy_w[COORD_BITS-1:0];
        w_m   = w_w[COORD_BITS-1:0];
        h_m   = h_w[COORD_BITS-1:0];
        dbl_x = {2'b00, cx_m, 1'b0};
        dbl_y = {2'b00, cy_m, 1'b0};
        ext_w = {3'b000, w_m};
        ext_h = {3'b000, h_m};
        new_d.idx  = loaded_reg[IDX_W-1:0];
        new_d.cls  = request.box_class;
        new_d.x1   = dbl_x - ext_w;
        new_d.y1   = dbl_y - ext_h;
        new_d.x2   = dbl_x + ext_w;
        new_d.y2   = dbl_y + ext_h;
        new_d.area = {w_m, 1'b0} * {h_m, 1'b0};
        new_d.supp = 1'b0;
        new_ent    = {request.score, new_d};
    end

    // Chain commands.
    always_comb
    begin
        ctrl.insert = accept && (loaded_reg < LW'(MAX_BOXES)) &&
                      (request.score > conf_reg);
        ctrl.shift  = ((state_reg == ST_SCAN) && cell_valid[0]) ||
                      (state_reg == ST_SWEEP);
        ctrl.clear  = (state_reg == ST_FINISH);
    end

    // Entries leaving the IoU pipeline re-enter the chain tail, marked
    // when they share the kept box's class and overlap it too much.
    always_comb
    begin
        head_d = cell_ent[0][DATA_W-1:0];
        tail_d = pipe_ent_reg[2][DATA_W-1:0];
        tail_d.supp = tail_d.supp ||
                      (pipe_valid_reg[2] && iou_hit && (tail_d.cls == k_reg.cls));
        tail_ent   = {pipe_ent_reg[2][ENT_W-1 -: SCORE_W], tail_d};
        tail_valid = (state_reg == ST_SWEEP) && pipe_valid_reg[2];
        head_idx_ext = {6'd0, head_d.idx};
        head_idx     = head_idx_ext[KEPT_IDX_W-1:0];
    end

    // Sorted chain of cells.
    for (genvar i = 0; i < MAX_BOXES; i++)
    begin : g_cell
        logic [ENT_W-1:0] left_ent;
        logic             left_valid;
        logic             left_go;
        logic [ENT_W-1:0] right_ent;
        logic             right_valid;

        if (i == 0)
        begin : g_head
            assign left_ent   = new_ent;
            assign left_valid = 1'b0;
            assign left_go    = 1'b0;
        end
        else
        begin : g_body
            assign left_ent   = cell_ent[i-1];
            assign left_valid = cell_valid[i-1];
            assign left_go    = cell_go[i-1];
        end

        if (i == MAX_BOXES - 1)
        begin : g_tail
            assign right_ent   = tail_ent;
            assign right_valid = tail_valid;
        end
        else
        begin : g_inner
            assign right_ent   = cell_ent[i+1];
            assign right_valid = cell_valid[i+1];
        end

        gbn_cell #(
            .ENT_W (ENT_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .new_ent     (new_ent),
            .left_ent    (left_ent),
            .left_valid  (left_valid),
            .left_go     (left_go),
            .right_ent   (right_ent),
            .right_valid (right_valid),
            .ent         (cell_ent[i]),
            .valid       (cell_valid[i]),
            .go          (cell_go[i])
        );
    end

    // Overlap test of the chain head against the latest kept box.
    gbn_iou #(
        .COORD_BITS (COORD_BITS)
    ) u_iou (
        .clk       (clk),
        .k_x1      (k_reg.x1),
        .k_y1      (k_reg.y1),
        .k_x2      (k_reg.x2),
        .k_y2      (k_reg.y2),
        .k_area    (k_reg.area),
        .c_x1      (head_d.x1),
        .c_y1      (head_d.y1),
        .c_x2      (head_d.x2),
        .c_y2      (head_d.y2),
        .c_area    (head_d.area),
        .threshold (overlap_reg),
        .hit       (iou_hit)
    );

    // Control state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            conf_reg          <= CONF_RESET;
            overlap_reg       <= OVERLAP_RESET;
            maxdet_reg        <= MAXDET_RESET;
            loaded_reg        <= '0;
            cnt_reg           <= '0;
            sweep_reg         <= '0;
            have_pend_reg     <= 1'b0;
            result_strobe_reg <= 1'b0;
            pipe_valid_reg[0] <= 1'b0;
            pipe_valid_reg[1] <= 1'b0;
            pipe_valid_reg[2] <= 1'b0;
        end
        else
        begin
            result_strobe_reg <= 1'b0;
            pipe_valid_reg[0] <= (state_reg == ST_SWEEP) && cell_valid[0];
            pipe_valid_reg[1] <= pipe_valid_reg[0];
            pipe_valid_reg[2] <= pipe_valid_reg[1];

            if (cfg_write)
            begin
                unique case (paddr[3:2])
                    REG_CONF:    conf_reg    <= pwdata[SCORE_W-1:0];
                    REG_OVERLAP: overlap_reg <= pwdata[SCORE_W-1:0];
                    REG_MAXDET:  maxdet_reg  <= pwdata[MAXDET_W-1:0];
                    default:     ;
                endcase
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (loaded_reg < LW'(MAX_BOXES))
                        begin
                            loaded_reg <= loaded_reg + LW'(1);
                        end
                        if (request.last_box)
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (!cell_valid[0])
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else if (!head_d.supp)
                    begin
                        // A kept box releases the one held before it.
                        result_strobe_reg <= have_pend_reg;
                        have_pend_reg     <= 1'b1;
                        cnt_reg           <= cnt_reg + MAXDET_W'(1);
                        sweep_reg         <= '0;
                        if (cnt_reg + MAXDET_W'(1) == limit)
                        begin
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            state_reg <= ST_SWEEP;
                        end
                    end
                end
                ST_SWEEP:
                begin
                    sweep_reg <= sweep_reg + SW'(1);
                    if (sweep_reg == SW'(RING - 1))
                    begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_FINISH:
                begin
                    result_strobe_reg <= 1'b1;
                    have_pend_reg     <= 1'b0;
                    loaded_reg        <= '0;
                    cnt_reg           <= '0;
                    state_reg         <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Held result, kept box and pipeline payload.
    always_ff @(posedge clk)
    begin
        pipe_ent_reg[0] <= cell_ent[0];
        pipe_ent_reg[1] <= pipe_ent_reg[0];
        pipe_ent_reg[2] <= pipe_ent_reg[1];

        if ((state_reg == ST_SCAN) && cell_valid[0] && !head_d.supp)
        begin
            result_reg.kept_index  <= pend_idx_reg;
            result_reg.kept_class  <= pend_cls_reg;
            result_reg.none_kept   <= 1'b0;
            result_reg.last_result <= 1'b0;
            pend_idx_reg           <= head_idx;
            pend_cls_reg           <= head_d.cls;
            k_reg                  <= head_d;
        end
        else if (state_reg == ST_FINISH)
        begin
            result_reg.kept_index  <= have_pend_reg ? pend_idx_reg : '0;
            result_reg.kept_class  <= have_pend_reg ? pend_cls_reg : '0;
            result_reg.none_kept   <= !have_pend_reg;
            result_reg.last_result <= 1'b1;
        end
    end

    assign result        = result_reg;
    assign result_strobe = result_strobe_reg;

`ifndef ASSERT_OFF
    // The final result of a set is given exactly as the block goes idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result.last_result |-> state_reg == ST_IDLE)
        else $error("final result while the set is still open");

    // An empty outcome is always the final result and carries zeros.
    a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result.none_kept |->
            result.last_result && result.kept_index == '0 && result.kept_class == '0)
        else $error("empty outcome malformed");

    // No more boxes are kept than the limit allows.
    a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= limit)
        else $error("kept count above limit");

    // The IoU pipeline carries entries only during a sweep.
    a_pipe_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_valid_reg[0] |-> $past(state_reg) == ST_SWEEP)
        else $error("pipeline entry outside a sweep");
`endif

endmodule

`default_nettype wire
